FILE: rtl/escaped_token_extractor_macros.svh
// ----------------------------------------------------------------------------
// Escaped token extractor assertion macros
// Short forms for the concurrent checks of the token extractor.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_TOKEN_EXTRACTOR_MACROS_SVH
`define ESCAPED_TOKEN_EXTRACTOR_MACROS_SVH

// same-cycle implication, off during reset
`define ETE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token extractor check failed");

// next-cycle implication, off during reset
`define ETE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token extractor check failed");

`endif

FILE: rtl/ete_pkg.sv
// ----------------------------------------------------------------------------
// Escaped token extractor package
// Shared types, character codes, phase codes and decode helpers.
// ----------------------------------------------------------------------------
package ete_pkg;

  localparam int unsigned MAX_TOKEN   = 255;
  localparam int unsigned TOKEN_LIMIT = (MAX_TOKEN > 255) ? 255 : MAX_TOKEN;
  localparam logic [7:0]  TOKEN_LIM_B = 8'(TOKEN_LIMIT);

  // result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // scan phases
  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_HEX1   = 3'd2;
  localparam logic [2:0] PH_HEX2   = 3'd3;
  localparam logic [2:0] PH_OCTZ   = 3'd4;
  localparam logic [2:0] PH_OCT2   = 3'd5;
  localparam logic [2:0] PH_OCT3   = 3'd6;

  // input characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D1     = 8'h31;
  localparam logic [7:0] CH_D7     = 8'h37;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6e;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // decoded letter escapes
  localparam logic [7:0] BY_NL  = 8'h0a;
  localparam logic [7:0] BY_TAB = 8'h09;
  localparam logic [7:0] BY_VT  = 8'h0b;
  localparam logic [7:0] BY_BS  = 8'h08;
  localparam logic [7:0] BY_CR  = 8'h0d;
  localparam logic [7:0] BY_FF  = 8'h0c;
  localparam logic [7:0] BY_BEL = 8'h07;

  typedef struct packed {
    logic [2:0]  phase;
    logic        in_quotes;
    logic [7:0]  emitted;
    logic [15:0] consumed;
    logic [7:0]  acc;
    logic        first_hex_valid;
    logic        overflow;
  } scan_state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        token_end;
    logic        bad_escape;
    logic        length_overflow;
    logic [7:0]  token_length;
    logic [15:0] next_position;
  } result_t;

  typedef struct packed {
    logic put;
    logic term;
    logic to_esc;
    logic flip_quote;
  } scan_act_t;

  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] cnt;
  } step_out_t;

  // action for a byte seen outside any escape
  function automatic scan_act_t scan_normal(input logic [7:0] b, input logic esc,
                                            input logic [7:0] em, input logic q);
    scan_act_t a;
    a = '0;
    if (!esc) begin
      if (em == 8'd0 && b == CH_SPACE) begin
        a = '0;
      end else if (b == CH_SPACE || b == CH_NL || b == CH_NUL) begin
        a.term = 1'b1;
      end else begin
        a.put = 1'b1;
      end
    end else if (b == CH_BSLASH) begin
      a.to_esc = 1'b1;
    end else if (b == CH_QUOTE) begin
      a.flip_quote = 1'b1;
    end else if (em == 8'd0 && b == CH_SPACE) begin
      a = '0;
    end else if ((!q && (b == CH_SPACE || b == CH_NL)) || b == CH_NUL) begin
      a.term = 1'b1;
    end else begin
      a.put = 1'b1;
    end
    return a;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    case (b) inside
      [CH_D0:CH_D9]: r = {1'b1, b[3:0]};
      [CH_LA:CH_LF]: r = {1'b1, 4'(b[3:0] + 4'd9)};
      [CH_UA:CH_UF]: r = {1'b1, 4'(b[3:0] + 4'd9)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ete_step.sv
// ----------------------------------------------------------------------------
// Escaped token extractor scan step
// Holds the scan state and decodes one byte into up to two result words.
// ----------------------------------------------------------------------------
module ete_step import ete_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        esc_en_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] base_i,
  output step_out_t   out_o
);

  scan_state_t st_q, st_d, work;
  scan_act_t   act;
  result_t     main_res, zero_res;
  logic [15:0] cons_n;
  logic [7:0]  em_mid, put_val;
  logic [4:0]  hv;
  logic        pre_put, pre_ok, ovf_mid;
  logic        use_normal, do_put, put_ok, do_end, end_bad, end_extra;

  always_comb begin
    cons_n  = st_q.consumed + 16'd1;
    pre_put = esc_en_i && st_q.phase == PH_OCTZ && !(byte_i inside {[CH_D0:CH_D9]});
    pre_ok  = pre_put && st_q.emitted < TOKEN_LIM_B;
    em_mid  = st_q.emitted + {7'd0, pre_ok};
    ovf_mid = st_q.overflow | (pre_put & ~pre_ok);
    act     = scan_normal(byte_i, esc_en_i, em_mid, st_q.in_quotes);
    hv      = hex_value(byte_i);

    work          = st_q;
    work.consumed = cons_n;
    do_put    = 1'b0;
    put_val   = byte_i;
    do_end    = 1'b0;
    end_bad   = 1'b0;
    end_extra = 1'b0;
    use_normal = !esc_en_i || st_q.phase == PH_NORMAL || st_q.phase > PH_OCT3;

    if (use_normal) begin
      work.phase = PH_NORMAL;
    end else begin
      case (st_q.phase)
        PH_ESC: begin
          work.phase = PH_NORMAL;
          do_put     = 1'b1;
          case (byte_i) inside
            CH_LN:     put_val = BY_NL;
            CH_LT:     put_val = BY_TAB;
            CH_LV:     put_val = BY_VT;
            CH_LB:     put_val = BY_BS;
            CH_LR:     put_val = BY_CR;
            CH_LF:     put_val = BY_FF;
            CH_LA:     put_val = BY_BEL;
            CH_BSLASH: put_val = CH_BSLASH;
            CH_QUOTE:  put_val = CH_QUOTE;
            CH_SPACE:  do_put  = st_q.emitted != 8'd0;
            CH_LX: begin
              do_put               = 1'b0;
              work.acc             = 8'd0;
              work.first_hex_valid = 1'b0;
              work.phase           = PH_HEX1;
            end
            CH_D0: begin
              do_put     = 1'b0;
              work.acc   = 8'd0;
              work.phase = PH_OCTZ;
            end
            [CH_D1:CH_D7]: begin
              do_put     = 1'b0;
              work.acc   = {5'd0, byte_i[2:0]};
              work.phase = PH_OCT2;
            end
            default: begin
              do_put    = 1'b0;
              do_end    = 1'b1;
              end_bad   = 1'b1;
              end_extra = 1'b1;
            end
          endcase
        end
        PH_HEX1: begin
          if (byte_i == CH_NUL) begin
            do_end = 1'b1;
          end else begin
            work.first_hex_valid = hv[4];
            work.acc             = hv[4] ? {hv[3:0], 4'd0} : 8'd0;
            work.phase           = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (byte_i == CH_NUL) begin
            do_end = 1'b1;
          end else begin
            work.phase = PH_NORMAL;
            do_put     = st_q.first_hex_valid && hv[4];
            put_val    = st_q.acc | {4'd0, hv[3:0]};
          end
        end
        PH_OCTZ: begin
          if (byte_i inside {[CH_D0:CH_D9]}) begin
            work.acc   = {5'd0, byte_i[2:0]};
            work.phase = PH_OCT3;
          end else begin
            // zero byte already taken, rescan this byte as plain text
            work.phase = PH_NORMAL;
            use_normal = 1'b1;
          end
        end
        PH_OCT2: begin
          if (byte_i == CH_NUL) begin
            do_end = 1'b1;
          end else begin
            work.acc   = {st_q.acc[4:0], byte_i[2:0]};
            work.phase = PH_OCT3;
          end
        end
        default: begin
          if (byte_i == CH_NUL) begin
            do_end = 1'b1;
          end else begin
            work.phase = PH_NORMAL;
            do_put     = 1'b1;
            put_val    = {st_q.acc[4:0], byte_i[2:0]};
          end
        end
      endcase
    end

    if (use_normal) begin
      if (act.to_esc) work.phase = PH_ESC;
      work.in_quotes = st_q.in_quotes ^ act.flip_quote;
      do_put  = act.put;
      put_val = byte_i;
      do_end  = act.term;
    end

    put_ok = do_put && em_mid < TOKEN_LIM_B;

    main_res = '0;
    if (do_end) begin
      main_res.token_end       = 1'b1;
      main_res.bad_escape      = end_bad;
      main_res.length_overflow = ovf_mid;
      main_res.token_length    = em_mid;
      main_res.next_position   = base_i + cons_n + {15'd0, end_extra};
    end else begin
      main_res.out_byte   = put_val;
      main_res.byte_valid = 1'b1;
    end

    zero_res            = '0;
    zero_res.byte_valid = 1'b1;

    out_o.r0  = pre_ok ? zero_res : main_res;
    out_o.r1  = main_res;
    out_o.cnt = {1'b0, pre_ok} + {1'b0, put_ok | do_end};

    if (do_end) begin
      st_d = '0;
    end else begin
      st_d          = work;
      st_d.emitted  = em_mid + {7'd0, put_ok};
      st_d.overflow = ovf_mid | (do_put & ~put_ok);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

FILE: rtl/ete_res_fifo.sv
// ----------------------------------------------------------------------------
// Escaped token extractor result queue
// Small queue taking up to two result words a cycle, giving one.
// ----------------------------------------------------------------------------
module ete_res_fifo import ete_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  step_out_t            wr_i,
  input  logic                 pop_i,
  output result_t              rd_o,
  output logic                 rd_valid_o,
  output logic [RES_CNT_W-1:0] count_o
);

  result_t              mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
  logic [RES_CNT_W-1:0] count_q, push_n;

  assign wr_ptr_1   = wr_ptr_q + RES_PTR_W'(1);
  assign push_n     = push_i ? RES_CNT_W'(wr_i.cnt) : '0;
  assign rd_o       = mem_q[rd_ptr_q];
  assign rd_valid_o = count_q != '0;
  assign count_o    = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i && wr_i.cnt != 2'd0) mem_q[wr_ptr_q] <= wr_i.r0;
    if (push_i && wr_i.cnt == 2'd2) mem_q[wr_ptr_1] <= wr_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n);
      if (pop_i) rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      count_q  <= count_q + push_n - (pop_i ? RES_CNT_W'(1) : '0);
    end
  end

endmodule

FILE: rtl/escaped_token_extractor.sv
// ----------------------------------------------------------------------------
// Escaped token extractor
// Streams text bytes and emits decoded token bytes followed by an end word.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle. A byte is held in the input register, decoded
// combinationally against the scan state and its results written to a
// four-word result queue, so a result word appears only once the queue holds
// it. Most bytes give at most one word; a lone \0 escape followed by a token
// byte or delimiter gives two, which the queue absorbs. The input stalls while
// the queue holds more than two words, so the sustained rate is one byte per
// cycle as long as words are drained one per cycle.
`include "escaped_token_extractor_macros.svh"

module escaped_token_extractor import ete_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic [15:0] base_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        token_end_o,
  output logic        bad_escape_o,
  output logic        length_overflow_o,
  output logic [7:0]  token_length_o,
  output logic [15:0] next_position_o
);

  logic                 esc_en_q;
  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic [15:0]          base_q;
  logic                 fire, load, pop;
  step_out_t            step_out;
  result_t              rd;
  logic [RES_CNT_W-1:0] count;

  // room for two words before taking a byte
  assign fire       = in_valid_q && count <= RES_CNT_W'(RES_DEPTH - 2);
  assign load       = !in_valid_q || fire;
  assign in_stall_o = in_valid_q && !fire;
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_en_q   <= 1'b1;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) esc_en_q <= cfg_wdata_i;
      if (load) in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q <= in_byte_i;
      base_q <= base_position_i;
    end
  end

  ete_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .esc_en_i (esc_en_q),
    .byte_i   (byte_q),
    .base_i   (base_q),
    .out_o    (step_out)
  );

  ete_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .wr_i       (step_out),
    .pop_i      (pop),
    .rd_o       (rd),
    .rd_valid_o (out_valid_o),
    .count_o    (count)
  );

  assign out_byte_o        = rd.out_byte;
  assign byte_valid_o      = rd.byte_valid;
  assign token_end_o       = rd.token_end;
  assign bad_escape_o      = rd.bad_escape;
  assign length_overflow_o = rd.length_overflow;
  assign token_length_o    = rd.token_length;
  assign next_position_o   = rd.next_position;

  `ETE_ASSERT_IMP(a_queue_bound, clk_i, rst_ni, 1'b1, count <= RES_CNT_W'(RES_DEPTH))
  `ETE_ASSERT_IMP(a_end_no_byte, clk_i, rst_ni, out_valid_o && token_end_o, !byte_valid_o && out_byte_o == 8'd0)
  `ETE_ASSERT_IMP(a_byte_no_end, clk_i, rst_ni, out_valid_o && byte_valid_o, !token_end_o && token_length_o == 8'd0 && next_position_o == 16'd0)
  `ETE_ASSERT_NXT(a_push_count, clk_i, rst_ni, fire && !pop, count == $past(count) + RES_CNT_W'($past(step_out.cnt)))

endmodule
